FILE: rtl/md5sh_pkg.sv
package md5sh_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam int WORD_ADDR_W = POS_W - 2;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0]       PAD_BYTE = 8'h80;
    localparam logic [POS_W-1:0] LEN_POS  = POS_W'(56);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BYTES - 1);
    localparam logic [5:0]       LAST_RND = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP_RD,
        ST_COMP_RND,
        ST_COMP_ADD,
        ST_PAD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       rnd;
        logic       add;
        logic       init;
        logic [5:0] rnd_idx;
    } t_core_ctl;

    function automatic logic [31:0] k_const(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // Message word used by a given round.
    function automatic logic [3:0] msg_idx(input logic [5:0] idx);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = idx[3:0];
        case (idx[5:4])
            2'd0:    g = i4;
            2'd1:    g = 4'(i4 * 4'd5 + 4'd1);
            2'd2:    g = 4'(i4 * 4'd3 + 4'd5);
            default: g = 4'(i4 * 4'd7);
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/md5sh_block_buf.sv
module md5sh_block_buf (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [md5sh_pkg::POS_W-1:0]         i_wr_pos,
    input  logic [7:0]                          i_wr_byte,
    input  logic [md5sh_pkg::WORD_ADDR_W-1:0]   i_rd_addr,
    output logic [31:0]                         o_rd_word
);
    import md5sh_pkg::*;

    logic [31:0] r_mem [0:BLOCK_BYTES/4-1];
    logic [31:0] r_rd_word;

    // Byte lanes are little-endian within each 32-bit word.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_pos[POS_W-1:2]][{i_wr_pos[1:0], 3'b000} +: 8] <= i_wr_byte;
        end
        r_rd_word <= r_mem[i_rd_addr];
    end

    assign o_rd_word = r_rd_word;

endmodule

FILE: rtl/md5sh_round.sv
module md5sh_round (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  md5sh_pkg::t_core_ctl        i_ctl,
    input  logic [31:0]                 i_msg_word,
    output logic [3:0][31:0]            o_chain
);
    import md5sh_pkg::*;

    logic [3:0][31:0] r_chain;
    logic [31:0]      r_a, r_b, r_c, r_d;
    logic [31:0]      f_val;
    logic [31:0]      sum;
    logic [4:0]       s_amt;
    logic [31:0]      rot;
    logic [31:0]      n_b;

    always_comb begin
        case (i_ctl.rnd_idx[5:4])
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f_val = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f_val = r_b ^ r_c ^ r_d;
            default: f_val = r_c ^ (r_b | ~r_d);
        endcase
        sum   = r_a + f_val + k_const(i_ctl.rnd_idx) + i_msg_word;
        s_amt = rot_amt(i_ctl.rnd_idx);
        rot   = (sum << s_amt) | (sum >> (6'd32 - {1'b0, s_amt}));
        n_b   = r_b + rot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= {IV_D, IV_C, IV_B, IV_A};
        end else if (i_ctl.init) begin
            r_chain <= {IV_D, IV_C, IV_B, IV_A};
        end else if (i_ctl.add) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (i_ctl.rnd) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= n_b;
        end
    end

    assign o_chain = r_chain;

endmodule

FILE: rtl/md5_stream_hasher.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+----------------------------------------
// input    | in        | i_valid / o_ready  | i_data_byte, i_byte_present,
//          |           |                    | i_end_of_message
// digest   | out       | o_valid / i_ready  | o_digest_word, o_word_index, o_last_word
//
// A byte that leaves the block short of full is taken without lowering o_ready.
// A full block then holds o_ready low through one read prefetch,
// 64 rounds through the single round unit and one chaining add.
// End of message writes padding one byte per cycle over one or two blocks, then
// holds o_ready low until the fourth digest word transfers.
// Reset (synchronous, active low) restores the initial chaining words and count.
module md5_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);
    import md5sh_pkg::*;

    t_state                 r_state, n_state;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [5:0]             r_rnd, n_rnd;
    logic [63:0]            r_bit_cnt, n_bit_cnt;
    logic                   r_fin, n_fin;
    logic                   r_sent80, n_sent80;
    logic                   r_len, n_len;
    logic [1:0]             r_widx, n_widx;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   wr_en;
    logic [7:0]             wr_byte;
    logic [7:0]             pad_byte;
    logic [WORD_ADDR_W-1:0] rd_addr;
    logic [31:0]            rd_word;
    t_core_ctl              core_ctl;
    logic [3:0][31:0]       chain;

    assign in_xfer  = i_valid & o_ready;
    assign out_xfer = o_valid & i_ready;

    // 0x80 first, zeros up to byte 56, then the bit count little-endian.
    always_comb begin
        if (!r_sent80) begin
            pad_byte = PAD_BYTE;
        end else if (r_len || r_pos == LEN_POS) begin
            pad_byte = r_bit_cnt[{r_pos[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_byte_present && r_pos == LAST_POS) begin
                        n_state = ST_COMP_RD;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_COMP_RD:  n_state = ST_COMP_RND;
            ST_COMP_RND: begin
                if (r_rnd == LAST_RND) begin
                    n_state = ST_COMP_ADD;
                end
            end
            ST_COMP_ADD: begin
                if (r_len) begin
                    n_state = ST_OUT;
                end else if (r_fin) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (r_pos == LAST_POS) begin
                    n_state = ST_COMP_RD;
                end
            end
            ST_OUT: begin
                if (out_xfer && r_widx == 2'd3) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = (r_state == ST_IDLE);
        o_valid          = (r_state == ST_OUT);
        wr_en            = 1'b0;
        wr_byte          = i_data_byte;
        rd_addr          = msg_idx(r_rnd);
        core_ctl         = '0;
        core_ctl.rnd_idx = r_rnd;
        n_pos            = r_pos;
        n_rnd            = r_rnd;
        n_bit_cnt        = r_bit_cnt;
        n_fin            = r_fin;
        n_sent80         = r_sent80;
        n_len            = r_len;
        n_widx           = r_widx;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_fin = i_end_of_message;
                    if (i_byte_present) begin
                        wr_en     = 1'b1;
                        n_pos     = r_pos + 1'b1;
                        n_bit_cnt = r_bit_cnt + 64'd8;
                    end
                end
            end
            ST_COMP_RD: begin
                core_ctl.load = 1'b1;
                rd_addr       = msg_idx(6'd0);
                n_rnd         = 6'd0;
            end
            ST_COMP_RND: begin
                core_ctl.rnd = 1'b1;
                // prefetch the word for the next round
                rd_addr      = msg_idx(r_rnd + 6'd1);
                n_rnd        = r_rnd + 6'd1;
            end
            ST_COMP_ADD: begin
                core_ctl.add = 1'b1;
            end
            ST_PAD: begin
                wr_en    = 1'b1;
                wr_byte  = pad_byte;
                n_pos    = r_pos + 1'b1;
                n_sent80 = 1'b1;
                if (r_sent80 && r_pos == LEN_POS) begin
                    n_len = 1'b1;
                end
            end
            ST_OUT: begin
                if (out_xfer) begin
                    n_widx = r_widx + 2'd1;
                    if (r_widx == 2'd3) begin
                        core_ctl.init = 1'b1;
                        n_bit_cnt     = 64'd0;
                        n_pos         = '0;
                        n_fin         = 1'b0;
                        n_sent80      = 1'b0;
                        n_len         = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_rnd     <= 6'd0;
            r_bit_cnt <= 64'd0;
            r_fin     <= 1'b0;
            r_sent80  <= 1'b0;
            r_len     <= 1'b0;
            r_widx    <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_rnd     <= n_rnd;
            r_bit_cnt <= n_bit_cnt;
            r_fin     <= n_fin;
            r_sent80  <= n_sent80;
            r_len     <= n_len;
            r_widx    <= n_widx;
        end
    end

    md5sh_block_buf u_block_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_pos  (r_pos),
        .i_wr_byte (wr_byte),
        .i_rd_addr (rd_addr),
        .o_rd_word (rd_word)
    );

    md5sh_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (core_ctl),
        .i_msg_word (rd_word),
        .o_chain    (chain)
    );

    assign o_digest_word = chain[r_widx];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == 2'd3);

endmodule
